[sv/assert_macros.svh]
// Assertion macros shared by the rate controller RTL.
// Needs nothing else; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold at a clock edge
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`endif

[sv/prcs_pkg.sv]
// Package of the probe rate controller: widths, reset values, register indexes
// and the structs passed between the sequencer, divider and register file.
// Depends on nothing.
package prcs_pkg;

    // Field widths
    localparam int RATE_W     = 32;
    localparam int UTIL_W     = 32;
    localparam int DIFF_W     = 33;
    localparam int FRAC_W     = 16;
    localparam int CNT_W      = 8;
    localparam int STEP_W     = 33;
    localparam int F2_W       = 11;
    localparam int W_W        = 24;
    localparam int AMAG_W     = 43;

    // Shared multiplier
    localparam int MUL_A_W    = 33;
    localparam int MUL_B_W    = 24;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    // Shared divider: numerator, divisor, quotient and step counts
    localparam int NUM_W      = 57;
    localparam int DEN_W      = 48;
    localparam int QUO_W      = 41;
    localparam int WIDE_Q     = 41;
    localparam int NARROW_Q   = 8;
    localparam int DIV_CNT_W  = 6;
    localparam int GMAG_W     = QUO_W;
    localparam int GAIN_SHIFT = 14;

    // Configuration port
    localparam int ADDR_W     = 5;
    localparam int APB_W      = 32;

    localparam logic [CNT_W-1:0]  CNT_MAX  = 8'd255;
    localparam logic [RATE_W-1:0] RATE_MAX = 32'hFFFF_FFFF;
    localparam logic [FRAC_W:0]   ONE_Q16  = 17'h1_0000;

    // Register reset values
    localparam logic [FRAC_W-1:0] PROBE_FRACTION_RST  = 16'd3277;
    localparam logic [FRAC_W-1:0] BASE_BOUND_RST      = 16'd3277;
    localparam logic [FRAC_W-1:0] BOUND_INCREMENT_RST = 16'd6554;
    localparam logic [RATE_W-1:0] MIN_RATE_RST        = 32'd25600;
    localparam logic [RATE_W-1:0] START_RATE_RST      = 32'd768000;

    typedef enum logic [2:0] {
        REG_PROBE_FRACTION  = 3'd0,
        REG_BASE_BOUND      = 3'd1,
        REG_BOUND_INCREMENT = 3'd2,
        REG_MIN_RATE        = 3'd3,
        REG_START_RATE      = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [FRAC_W-1:0] probe_fraction;
        logic [FRAC_W-1:0] base_bound;
        logic [FRAC_W-1:0] bound_increment;
        logic [RATE_W-1:0] min_rate;
        logic [RATE_W-1:0] start_rate;
        logic              load_rate;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic wide;
    } div_cmd_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_stat_t;

endpackage

[sv/prcs_if.sv]
// Valid/ready channel interfaces for probe round items and rate results.
// Depends on prcs_pkg for the field widths.
interface prcs_in_if;
    import prcs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [UTIL_W-1:0] util_first;
    logic signed [UTIL_W-1:0] util_second;

    modport source (output valid, output util_first, output util_second, input ready);
    modport sink   (input valid, input util_first, input util_second, output ready);
endinterface

interface prcs_out_if;
    import prcs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic        [RATE_W-1:0] new_rate;
    logic        [RATE_W-1:0] probe_low_rate;
    logic        [RATE_W-1:0] probe_high_rate;
    logic signed [STEP_W-1:0] rate_step;
    logic                     step_clamped;
    logic        [CNT_W-1:0]  streak_length;

    modport source (
        output valid, output new_rate, output probe_low_rate, output probe_high_rate,
        output rate_step, output step_clamped, output streak_length, input ready
    );
    modport sink (
        input valid, input new_rate, input probe_low_rate, input probe_high_rate,
        input rate_step, input step_clamped, input streak_length, output ready
    );
endinterface

[sv/prcs_mul.sv]
// Shared multiplier of the rate controller, one product per issue, registered.
// Depends on prcs_pkg for the operand widths.
module prcs_mul (
    input  logic                         clk,
    input  logic                         en,
    input  logic [prcs_pkg::MUL_A_W-1:0] a,
    input  logic [prcs_pkg::MUL_B_W-1:0] b,
    output logic [prcs_pkg::MUL_P_W-1:0] prod
);
    import prcs_pkg::*;

    logic [MUL_P_W-1:0] prod_reg;

    // Register the product on issue, hold it otherwise
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= MUL_P_W'(a) * MUL_P_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule

[sv/prcs_div.sv]
// Shared shift-subtract divider, one quotient bit per cycle.
// Wide pass: 41 quotient bits; narrow pass: 8 bits; both set an overflow flag.
// Depends on prcs_pkg.
module prcs_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  prcs_pkg::div_cmd_t         cmd,
    input  logic [prcs_pkg::NUM_W-1:0] num,
    input  logic [prcs_pkg::DEN_W-1:0] den,
    output prcs_pkg::div_stat_t        stat,
    output logic [prcs_pkg::QUO_W-1:0] quo
);
    import prcs_pkg::*;

    localparam int HEAD_W = NUM_W - WIDE_Q;

    logic                 busy_reg;
    logic                 done_reg;
    logic                 ovf_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [QUO_W-1:0]     sh_reg;
    logic [QUO_W-1:0]     quo_reg;

    logic [HEAD_W-1:0]    head;
    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 ge;

    // Top bits of the numerator seed the remainder in a wide pass
    assign head  = num[NUM_W-1:WIDE_Q];

    // One restoring step
    assign trial = {rem_reg, sh_reg[QUO_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    // Sequence the steps and flag completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                if (cmd.wide)
                begin
                    cnt_reg <= DIV_CNT_W'(WIDE_Q);
                    ovf_reg <= {{(DEN_W-HEAD_W){1'b0}}, head} >= den;
                end
                else
                begin
                    cnt_reg <= DIV_CNT_W'(NARROW_Q);
                    ovf_reg <= num[NUM_W-1:NARROW_Q]
                               >= {{(NUM_W-NARROW_Q-DEN_W){1'b0}}, den};
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Load operands, then shift in dividend bits and subtract
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            den_reg <= den;
            quo_reg <= '0;
            if (cmd.wide)
            begin
                rem_reg <= {{(DEN_W-HEAD_W){1'b0}}, head};
                sh_reg  <= num[WIDE_Q-1:0];
            end
            else
            begin
                rem_reg <= num[NARROW_Q+DEN_W-1:NARROW_Q];
                sh_reg  <= {num[NARROW_Q-1:0], {(QUO_W-NARROW_Q){1'b0}}};
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
            sh_reg  <= {sh_reg[QUO_W-2:0], 1'b0};
        end
    end

    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;
    assign quo       = quo_reg;

endmodule

[sv/prcs_cfg.sv]
// APB-style register file of the rate controller: five tuning registers.
// Depends on prcs_pkg for register indexes, reset values and cfg_t.
module prcs_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [prcs_pkg::ADDR_W-1:0] paddr,
    input  logic [prcs_pkg::APB_W-1:0]  pwdata,
    output logic [prcs_pkg::APB_W-1:0]  prdata,
    output logic                        pready,
    output prcs_pkg::cfg_t              cfg
);
    import prcs_pkg::*;

    logic [FRAC_W-1:0] probe_fraction_reg;
    logic [FRAC_W-1:0] base_bound_reg;
    logic [FRAC_W-1:0] bound_increment_reg;
    logic [RATE_W-1:0] min_rate_reg;
    logic [RATE_W-1:0] start_rate_reg;
    logic              wr;
    reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    // Write registers on the access phase; drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_fraction_reg  <= PROBE_FRACTION_RST;
            base_bound_reg      <= BASE_BOUND_RST;
            bound_increment_reg <= BOUND_INCREMENT_RST;
            min_rate_reg        <= MIN_RATE_RST;
            start_rate_reg      <= START_RATE_RST;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_PROBE_FRACTION:  probe_fraction_reg  <= pwdata[FRAC_W-1:0];
                REG_BASE_BOUND:      base_bound_reg      <= pwdata[FRAC_W-1:0];
                REG_BOUND_INCREMENT: bound_increment_reg <= pwdata[FRAC_W-1:0];
                REG_MIN_RATE:        min_rate_reg        <= pwdata[RATE_W-1:0];
                REG_START_RATE:      start_rate_reg      <= pwdata[RATE_W-1:0];
                default:             ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            REG_PROBE_FRACTION:  prdata = APB_W'(probe_fraction_reg);
            REG_BASE_BOUND:      prdata = APB_W'(base_bound_reg);
            REG_BOUND_INCREMENT: prdata = APB_W'(bound_increment_reg);
            REG_MIN_RATE:        prdata = APB_W'(min_rate_reg);
            REG_START_RATE:      prdata = APB_W'(start_rate_reg);
            default:             prdata = '0;
        endcase
    end

    // A start rate write also reloads the running rate
    assign cfg.probe_fraction  = probe_fraction_reg;
    assign cfg.base_bound      = base_bound_reg;
    assign cfg.bound_increment = bound_increment_reg;
    assign cfg.min_rate        = min_rate_reg;
    assign cfg.start_rate      = pwdata[RATE_W-1:0];
    assign cfg.load_rate       = wr && (idx == REG_START_RATE);

endmodule

[sv/probe_rate_controller_step_unit.sv]
// Probe round rate controller. Each item carries the utilities of the low and
// high probe intervals; the block amplifies their difference by the streak,
// turns it into a rate step by dividing by 2*eps*rate, clamps it to the
// dynamic bound, moves and floors the rate and returns the new rate, both
// probe rates, the step, the clamp flag and the streak. A small sequencer
// drives one shared multiplier and one shared shift-subtract divider; an item
// holds the block through eight multiplier issues, the 41 quotient bits of the
// step division and, unless the step is clamped or the bound count needs no
// quotient, the 8 bits of the bound count division. Input ready is high only
// while the sequencer is idle and no finished item waits for the output
// register; a result sitting in the output register does not hold the next
// item off, but a stalled receiver adds its stall to the item time once both
// are full. Writing the start rate register also loads the running rate. No
// clearing pass follows reset.
`include "assert_macros.svh"

module probe_rate_controller_step_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [prcs_pkg::ADDR_W-1:0] paddr,
    input  logic [prcs_pkg::APB_W-1:0]  pwdata,
    output logic [prcs_pkg::APB_W-1:0]  prdata,
    output logic                        pready,
    prcs_in_if.sink                     in_ch,
    prcs_out_if.source                  out_ch
);
    import prcs_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE      = 14'b00_0000_0000_0001,
        ST_MUL_W     = 14'b00_0000_0000_0010,
        ST_MUL_AMAG  = 14'b00_0000_0000_0100,
        ST_MUL_DIV   = 14'b00_0000_0000_1000,
        ST_MUL_BND   = 14'b00_0000_0001_0000,
        ST_MUL_BASE  = 14'b00_0000_0010_0000,
        ST_MUL_DR    = 14'b00_0000_0100_0000,
        ST_DIV1      = 14'b00_0000_1000_0000,
        ST_DIV1_WAIT = 14'b00_0001_0000_0000,
        ST_BS        = 14'b00_0010_0000_0000,
        ST_DIV2_WAIT = 14'b00_0100_0000_0000,
        ST_UPDATE    = 14'b00_1000_0000_0000,
        ST_MUL_LO    = 14'b01_0000_0000_0000,
        ST_MUL_HI    = 14'b10_0000_0000_0000
    } state_t;

    // FINISH is folded into the idle check below through fin_reg
    state_t               state_reg;
    state_t               state_next;
    logic                 fin_reg;

    cfg_t                 cfg;

    // Controller state
    logic [RATE_W-1:0]    rate_reg;
    logic [CNT_W-1:0]     streak_reg;
    logic                 last_up_reg;
    logic [CNT_W-1:0]     bs_reg;

    // Per-item working registers
    logic                 neg_reg;
    logic [DIFF_W-1:0]    dmag_reg;
    logic [F2_W-1:0]      f2_reg;
    logic [W_W-1:0]       w_reg;
    logic [AMAG_W-1:0]    amag_reg;
    logic [DEN_W-1:0]     div_reg;
    logic [GMAG_W-1:0]    bound_reg;
    logic [DEN_W-1:0]     base_reg;
    logic [DEN_W-1:0]     dr_reg;
    logic [GMAG_W-1:0]    gmag_reg;
    logic                 clamped_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [RATE_W-1:0]    lo_reg;

    // Output register
    logic                 out_valid_reg;
    logic [RATE_W-1:0]    out_rate_reg;
    logic [RATE_W-1:0]    out_lo_reg;
    logic [RATE_W-1:0]    out_hi_reg;
    logic [STEP_W-1:0]    out_step_reg;
    logic                 out_clamped_reg;
    logic [CNT_W-1:0]     out_streak_reg;

    // Shared units
    logic                 mul_en;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [MUL_P_W-1:0]   prod;
    div_cmd_t             div_cmd;
    div_stat_t            div_stat;
    logic [NUM_W-1:0]     div_num;
    logic [DEN_W-1:0]     div_den;
    logic [QUO_W-1:0]     div_quo;

    // Combinational helpers
    logic                 in_acc;
    logic                 out_free;
    logic [DIFF_W-1:0]    diff;
    logic                 up;
    logic [CNT_W-1:0]     streak_new;
    logic [F2_W-1:0]      k_ext;
    logic [F2_W-1:0]      f2_new;
    logic [DIFF_W-1:0]    dmag_new;
    logic                 zero_amag;
    logic                 clamp_now;
    logic [GMAG_W-1:0]    gmag_now;
    logic [NUM_W-1:0]     lhs;
    logic [NUM_W-1:0]     base_ext;
    logic                 lhs_lt_base;
    logic [NUM_W-1:0]     rem_num;
    logic                 need_div2;
    logic [CNT_W-1:0]     bs_inc;
    logic [CNT_W-1:0]     bs_direct;
    logic [CNT_W-1:0]     q8;
    logic [RATE_W-1:0]    gsat;
    logic [RATE_W:0]      rate_add;
    logic [RATE_W-1:0]    nr_sat;
    logic [RATE_W-1:0]    nr;
    logic [RATE_W:0]      hi_full;
    logic [RATE_W-1:0]    hi_sat;
    logic [FRAC_W:0]      lo_factor;
    logic [FRAC_W:0]      hi_factor;

    prcs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    prcs_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    prcs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // Handshakes
    assign in_ch.ready = (state_reg == ST_IDLE) && !fin_reg;
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    // Direction, streak and amplifier factor of the incoming item
    assign diff       = {in_ch.util_second[UTIL_W-1], in_ch.util_second}
                      - {in_ch.util_first[UTIL_W-1], in_ch.util_first};
    assign up         = !diff[DIFF_W-1] && (diff != '0);
    assign streak_new = (up != last_up_reg) ? CNT_W'(1)
                      : (streak_reg == CNT_MAX) ? CNT_MAX : streak_reg + 1'b1;
    assign k_ext      = F2_W'(streak_new);
    assign f2_new     = (streak_new <= CNT_W'(3)) ? (k_ext << 1)
                      : (k_ext << 2) + k_ext - F2_W'(6);
    assign dmag_new   = diff[DIFF_W-1] ? ('0 - diff) : diff;

    // Step quotient against the bound
    assign zero_amag = (amag_reg == '0);
    assign clamp_now = !zero_amag && (div_stat.ovf || (div_quo > bound_reg));
    assign gmag_now  = zero_amag ? '0 : (clamp_now ? bound_reg : div_quo);

    // Bound count decision
    assign lhs         = {gmag_reg, {(NUM_W-GMAG_W){1'b0}}};
    assign base_ext    = {{(NUM_W-DEN_W){1'b0}}, base_reg};
    assign lhs_lt_base = lhs < base_ext;
    assign rem_num     = lhs - base_ext;
    assign need_div2   = !clamped_reg && (rate_reg != '0) && !lhs_lt_base
                      && (cfg.bound_increment != '0);
    assign bs_inc      = (bs_reg == CNT_MAX) ? CNT_MAX : bs_reg + 1'b1;
    assign bs_direct   = clamped_reg ? bs_inc
                      : ((rate_reg == '0) || lhs_lt_base) ? '0 : CNT_MAX;
    assign q8          = div_quo[CNT_W-1:0];

    // Rate move, saturation and floor
    assign gsat     = (gmag_reg > GMAG_W'(RATE_MAX)) ? RATE_MAX : gmag_reg[RATE_W-1:0];
    assign rate_add = {1'b0, rate_reg} + {1'b0, gsat};
    always_comb
    begin
        if (neg_reg)
        begin
            nr_sat = (gsat > rate_reg) ? '0 : rate_reg - gsat;
        end
        else
        begin
            nr_sat = rate_add[RATE_W] ? RATE_MAX : rate_add[RATE_W-1:0];
        end
        nr = (nr_sat < cfg.min_rate) ? cfg.min_rate : nr_sat;
    end

    // Probe rate factors and the saturated high probe rate
    assign lo_factor = ONE_Q16 - {1'b0, cfg.probe_fraction};
    assign hi_factor = ONE_Q16 + {1'b0, cfg.probe_fraction};
    assign hi_full   = prod[FRAC_W+RATE_W:FRAC_W];
    assign hi_sat    = hi_full[RATE_W] ? RATE_MAX : hi_full[RATE_W-1:0];

    // Multiplier operand selection
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(rate_reg);
        mul_b  = '0;
        unique case (state_reg)
            ST_MUL_W:
            begin
                mul_a = MUL_A_W'(bs_reg);
                mul_b = MUL_B_W'(cfg.bound_increment);
            end
            ST_MUL_AMAG:
            begin
                mul_a = dmag_reg;
                mul_b = MUL_B_W'(f2_reg);
            end
            ST_MUL_DIV:  mul_b = MUL_B_W'(cfg.probe_fraction);
            ST_MUL_BND:  mul_b = w_reg;
            ST_MUL_BASE: mul_b = MUL_B_W'(cfg.base_bound);
            ST_MUL_DR:   mul_b = MUL_B_W'(cfg.bound_increment);
            ST_MUL_LO:   mul_b = MUL_B_W'(lo_factor);
            ST_MUL_HI:   mul_b = MUL_B_W'(hi_factor);
            default:     mul_en = 1'b0;
        endcase
    end

    // Divider commands
    always_comb
    begin
        div_cmd.start = 1'b0;
        div_cmd.wide  = 1'b0;
        div_num       = rem_num;
        div_den       = dr_reg;
        if (state_reg == ST_DIV1)
        begin
            div_cmd.start = 1'b1;
            div_cmd.wide  = 1'b1;
            div_num       = {amag_reg, {GAIN_SHIFT{1'b0}}};
            div_den       = div_reg;
        end
        else if (state_reg == ST_BS)
        begin
            div_cmd.start = need_div2;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_MUL_W;
                end
            end
            ST_MUL_W:     state_next = ST_MUL_AMAG;
            ST_MUL_AMAG:  state_next = ST_MUL_DIV;
            ST_MUL_DIV:   state_next = ST_MUL_BND;
            ST_MUL_BND:   state_next = ST_MUL_BASE;
            ST_MUL_BASE:  state_next = ST_MUL_DR;
            ST_MUL_DR:    state_next = ST_DIV1;
            ST_DIV1:      state_next = ST_DIV1_WAIT;
            ST_DIV1_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_BS;
                end
            end
            ST_BS:        state_next = need_div2 ? ST_DIV2_WAIT : ST_UPDATE;
            ST_DIV2_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:    state_next = ST_MUL_LO;
            ST_MUL_LO:    state_next = ST_MUL_HI;
            ST_MUL_HI:    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Control state, controller state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fin_reg       <= 1'b0;
            rate_reg      <= START_RATE_RST;
            streak_reg    <= CNT_W'(1);
            last_up_reg   <= 1'b0;
            bs_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Hold the finished item until the output register frees
            if (state_reg == ST_MUL_HI)
            begin
                fin_reg <= 1'b1;
            end
            else if (fin_reg && out_free)
            begin
                fin_reg <= 1'b0;
            end

            if (fin_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg.load_rate)
            begin
                rate_reg <= cfg.start_rate;
            end
            else if (state_reg == ST_UPDATE)
            begin
                rate_reg <= nr;
            end

            if (in_acc)
            begin
                streak_reg  <= streak_new;
                last_up_reg <= up;
                if (up != last_up_reg)
                begin
                    bs_reg <= '0;
                end
            end
            else if ((state_reg == ST_BS) && !need_div2)
            begin
                bs_reg <= bs_direct;
            end
            else if ((state_reg == ST_DIV2_WAIT) && div_stat.done)
            begin
                bs_reg <= (q8 == CNT_MAX) ? CNT_MAX : q8 + 1'b1;
            end
        end
    end

    // Capture products and quotients as they arrive
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            neg_reg  <= diff[DIFF_W-1];
            dmag_reg <= dmag_new;
            f2_reg   <= f2_new;
        end
        unique case (state_reg)
            ST_MUL_AMAG: w_reg     <= W_W'(cfg.base_bound) + prod[W_W-1:0];
            ST_MUL_DIV:  amag_reg  <= prod[AMAG_W-1:0];
            ST_MUL_BND:  div_reg   <= prod[DEN_W-1:0];
            ST_MUL_BASE: bound_reg <= prod[FRAC_W+GMAG_W-1:FRAC_W];
            ST_MUL_DR:   base_reg  <= prod[DEN_W-1:0];
            ST_DIV1:     dr_reg    <= prod[DEN_W-1:0];
            ST_DIV1_WAIT:
            begin
                if (div_stat.done)
                begin
                    gmag_reg    <= gmag_now;
                    clamped_reg <= clamp_now;
                end
            end
            ST_UPDATE:   step_reg  <= neg_reg ? ('0 - {1'b0, gsat}) : {1'b0, gsat};
            ST_MUL_HI:   lo_reg    <= prod[FRAC_W+RATE_W-1:FRAC_W];
            default:     ;
        endcase
        if (fin_reg && out_free)
        begin
            out_rate_reg    <= rate_reg;
            out_lo_reg      <= lo_reg;
            out_hi_reg      <= hi_sat;
            out_step_reg    <= step_reg;
            out_clamped_reg <= clamped_reg;
            out_streak_reg  <= streak_reg;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.new_rate        = out_rate_reg;
    assign out_ch.probe_low_rate  = out_lo_reg;
    assign out_ch.probe_high_rate = out_hi_reg;
    assign out_ch.rate_step       = out_step_reg;
    assign out_ch.step_clamped    = out_clamped_reg;
    assign out_ch.streak_length   = out_streak_reg;

    // Checks
    `ASSERT_CLK(a_busy_after_accept, clk, rst_n,
                (in_ch.valid && in_ch.ready) |=> !in_ch.ready,
                "input ready high right after an accepted item")
    `ASSERT_NEVER(a_div_done_in_wait, clk, rst_n,
                  div_stat.done && (state_reg != ST_DIV1_WAIT)
                  && (state_reg != ST_DIV2_WAIT),
                  "divider finished outside a wait state")
    `ASSERT_CLK(a_probe_order, clk, rst_n,
                out_ch.valid |-> ((out_ch.probe_low_rate <= out_ch.new_rate)
                && (out_ch.new_rate <= out_ch.probe_high_rate)),
                "probe rates do not bracket the new rate")

endmodule

[verif/probe_rate_controller_step_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench of the probe round rate controller: drives utility pairs and APB
// register writes, predicts each rate update in its own model and checks it.
// Depends on prcs_pkg, the prcs_in_if/prcs_out_if channels and the RTL top.
module probe_rate_controller_step_unit_tb;
    import prcs_pkg::*;

    localparam int LATENCY_SLACK = 80;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int ROUNDS_PER_PHASE = 100;
    // First byte address past the register map
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = 5'd20;
    localparam logic signed [UTIL_W-1:0] UTIL_MIN = 32'sh8000_0000;
    localparam logic signed [UTIL_W-1:0] UTIL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [RATE_W-1:0] new_rate;
        logic [RATE_W-1:0] low_rate;
        logic [RATE_W-1:0] high_rate;
        logic [STEP_W-1:0] step;
        logic              clamped;
        logic [CNT_W-1:0]  streak;
    } rate_update_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    prcs_in_if  in_ch ();
    prcs_out_if out_ch ();

    probe_rate_controller_step_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Register copies and controller state of the prediction
    logic [FRAC_W-1:0] cfg_eps   = PROBE_FRACTION_RST;
    logic [FRAC_W-1:0] cfg_omega = BASE_BOUND_RST;
    logic [FRAC_W-1:0] cfg_delta = BOUND_INCREMENT_RST;
    logic [RATE_W-1:0] cfg_floor = MIN_RATE_RST;
    logic [RATE_W-1:0] cfg_start = START_RATE_RST;
    logic [RATE_W-1:0] rate_now  = START_RATE_RST;
    logic [CNT_W-1:0]  streak    = 8'd1;
    logic              went_up   = 1'b0;
    logic [CNT_W-1:0]  bound_cnt = '0;

    rate_update_t pending_updates[$];
    rate_update_t oldest_update;
    int           errors = 0;
    bit           idle_on = 1'b1;
    int           sink_hold = 0;
    int           sink_gap = 0;

    always #5 clk = ~clk;

    // Work out the update that one probe round causes and advance the state
    function automatic rate_update_t rate_update(input logic signed [UTIL_W-1:0] u1,
                                                 input logic signed [UTIL_W-1:0] u2);
        longint          diff, moved, total;
        longint unsigned k, f2, dmag, amag, r, w, bnd, divisor, gmag;
        longint unsigned lhs, base, q, nr, lo, hi;
        logic            is_up, is_neg, clip;
        rate_update_t    res;

        diff = longint'(u2) - longint'(u1);
        is_up = (diff > 0);
        is_neg = (diff < 0);

        // Restart the streak on a change of direction
        if (is_up != went_up) begin
            streak = 8'd1;
            bound_cnt = '0;
        end else if (streak != CNT_MAX) begin
            streak = streak + 8'd1;
        end
        went_up = is_up;

        k = 64'(streak);
        f2 = (k <= 3) ? 2 * k : 5 * k - 6;
        dmag = is_neg ? -diff : diff;
        amag = dmag * f2;

        r = 64'(rate_now);
        w = 64'(cfg_omega) + 64'(bound_cnt) * 64'(cfg_delta);
        bnd = (w * r) >> 16;
        divisor = 64'(cfg_eps) * r;

        // Step from the amplified difference, clamped to the dynamic bound
        if (divisor == 0) begin
            clip = (amag != 0);
            gmag = clip ? bnd : 64'd0;
        end else begin
            gmag = (amag << GAIN_SHIFT) / divisor;
            clip = (gmag > bnd);
            if (clip)
                gmag = bnd;
        end

        // Bound count for the next round
        if (clip) begin
            if (bound_cnt != CNT_MAX)
                bound_cnt = bound_cnt + 8'd1;
        end else if (r == 0) begin
            bound_cnt = '0;
        end else begin
            lhs = gmag << 16;
            base = 64'(cfg_omega) * r;
            if (lhs < base)
                bound_cnt = '0;
            else if (cfg_delta == 0)
                bound_cnt = CNT_MAX;
            else begin
                q = (lhs - base) / (64'(cfg_delta) * r);
                bound_cnt = (q >= 64'(CNT_MAX)) ? CNT_MAX : 8'(q + 1);
            end
        end

        // Move the rate, saturate it and apply the floor
        if (gmag > 64'hFFFF_FFFF)
            gmag = 64'hFFFF_FFFF;
        moved = is_neg ? -longint'(gmag) : longint'(gmag);
        total = longint'(r) + moved;
        if (total < 0)
            nr = 0;
        else if (total > 64'sd4294967295)
            nr = 64'hFFFF_FFFF;
        else
            nr = total;
        if (nr < 64'(cfg_floor))
            nr = 64'(cfg_floor);
        rate_now = nr[31:0];

        lo = (nr * (64'd65536 - 64'(cfg_eps))) >> 16;
        hi = (nr * (64'd65536 + 64'(cfg_eps))) >> 16;
        if (hi > 64'hFFFF_FFFF)
            hi = 64'hFFFF_FFFF;

        res.new_rate  = nr[31:0];
        res.low_rate  = lo[31:0];
        res.high_rate = hi[31:0];
        res.step      = moved[32:0];
        res.clamped   = clip;
        res.streak    = streak;
        return res;
    endfunction

    // Mostly no gap, some short ones, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned roll;

        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Offer one probe round; leave valid high when no gap follows
    task automatic send_round(input logic signed [UTIL_W-1:0] first,
                              input logic signed [UTIL_W-1:0] second);
        int unsigned gap;

        in_ch.util_first  <= first;
        in_ch.util_second <= second;
        in_ch.valid       <= 1'b1;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        pending_updates.insert(pending_updates.size(), rate_update(first, second));
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and hold until every outstanding result has come back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [APB_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_register(input reg_idx_t idx, input logic [APB_W-1:0] data);
        apb_write({idx, 2'b00}, data);
        case (idx)
            REG_PROBE_FRACTION:  cfg_eps   = data[FRAC_W-1:0];
            REG_BASE_BOUND:      cfg_omega = data[FRAC_W-1:0];
            REG_BOUND_INCREMENT: cfg_delta = data[FRAC_W-1:0];
            REG_MIN_RATE:        cfg_floor = data;
            REG_START_RATE:
            begin
                cfg_start = data;
                rate_now  = data;
            end
            default: ;
        endcase
    endtask

    // Read every register back and compare with the copies
    task automatic check_registers();
        reg_idx_t         idx;
        logic [APB_W-1:0] got, want;

        idx = idx.first();
        repeat (idx.num())
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {idx, 2'b00};
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (pready !== 1'b1);
            got = prdata;
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge clk);
            case (idx)
                REG_PROBE_FRACTION:  want = 32'(cfg_eps);
                REG_BASE_BOUND:      want = 32'(cfg_omega);
                REG_BOUND_INCREMENT: want = 32'(cfg_delta);
                REG_MIN_RATE:        want = cfg_floor;
                default:             want = cfg_start;
            endcase
            if (got !== want) begin
                $display("%0t: register %s read mismatch: expected %h, actual %h",
                         $time, idx.name(), want, got);
                errors++;
            end
            idx = idx.next();
        end
    endtask

    task automatic configure(input logic [FRAC_W-1:0] eps, input logic [FRAC_W-1:0] omega,
                             input logic [FRAC_W-1:0] delta, input logic [RATE_W-1:0] floor_rate,
                             input logic [RATE_W-1:0] start);
        // Junk in the upper half of the narrow registers must be dropped
        set_register(REG_PROBE_FRACTION, {16'($urandom), eps});
        set_register(REG_BASE_BOUND, {16'($urandom), omega});
        set_register(REG_BOUND_INCREMENT, {16'($urandom), delta});
        set_register(REG_MIN_RATE, floor_rate);
        set_register(REG_START_RATE, start);
        check_registers();
    endtask

    task automatic test_reset_defaults();
        check_registers();
        send_round(32'sd0, 32'sd0);
        send_round(32'sd0, 32'sh0001_0000);
        send_round(32'sh0001_0000, 32'sd0);
        wait_drained();
    endtask

    task automatic test_utility_extremes();
        send_round(UTIL_MIN, UTIL_MAX);
        send_round(UTIL_MAX, UTIL_MIN);
        send_round(UTIL_MAX, UTIL_MAX);
        send_round(UTIL_MIN, UTIL_MIN);
        send_round(-32'sd1, 32'sd0);
        send_round(32'sd0, -32'sd1);
        // Build a rising streak past three to reach the steeper amplifier
        repeat (6) send_round(32'sd0, 32'sh0010_0000);
        wait_drained();
    endtask

    task automatic test_special_cases();
        // Zero probe fraction: the step is clamped to the bound for any nonzero difference
        set_register(REG_PROBE_FRACTION, 32'd0);
        send_round(32'sd0, 32'sd1000);
        send_round(32'sd5, 32'sd5);
        wait_drained();

        // Zero rate: no divisor and no bound
        set_register(REG_PROBE_FRACTION, 32'(PROBE_FRACTION_RST));
        set_register(REG_MIN_RATE, 32'd0);
        set_register(REG_START_RATE, 32'd0);
        send_round(32'sd0, 32'sd0);
        send_round(32'sd0, 32'sh0010_0000);
        wait_drained();

        // Zero increment with a zero step at a zero base bound
        set_register(REG_START_RATE, 32'd768000);
        set_register(REG_BASE_BOUND, 32'd0);
        set_register(REG_BOUND_INCREMENT, 32'd0);
        send_round(32'sd3, 32'sd3);
        send_round(32'sd3, 32'sd3);
        wait_drained();

        // Start rate near the top with a tiny probe fraction, then one rising and two falling rounds
        set_register(REG_PROBE_FRACTION, 32'd1);
        set_register(REG_BASE_BOUND, 32'd65535);
        set_register(REG_BOUND_INCREMENT, 32'd65535);
        set_register(REG_MIN_RATE, 32'd4096);
        set_register(REG_START_RATE, 32'hFFFF_FF00);
        send_round(32'sd0, 32'sh0010_0000);
        send_round(32'sh0010_0000, 32'sd0);
        send_round(32'sh0010_0000, 32'sd0);
        wait_drained();

        // A write past the register map changes nothing
        apb_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
        check_registers();
        send_round(32'sd0, 32'sh0000_8000);
        wait_drained();
    endtask

    // Runs of same-direction rounds with random magnitudes, plus some noise
    task automatic random_rounds(input int count, input int hold_at, input int pause_at);
        int          run_left;
        bit          run_up;
        int unsigned mag, half;
        longint      centre, u1, u2;

        run_left = 0;
        run_up = 1'b0;
        for (int n = 0; n < count; n++) begin
            if (n == hold_at)
                sink_hold = HOLD_OFF_CYCLES;
            if (n == pause_at)
                wait_drained();
            if (run_left == 0) begin
                run_up = $urandom_range(0, 1);
                run_left = $urandom_range(1, 12);
            end
            run_left--;
            if ($urandom_range(0, 9) == 0) begin
                send_round($urandom, $urandom);
            end else if ($urandom_range(0, 29) == 0) begin
                u1 = longint'($signed($urandom));
                send_round(u1[31:0], u1[31:0]);
            end else begin
                mag = $urandom >> $urandom_range(1, 31);
                half = mag >> 1;
                centre = longint'($signed($urandom)) >>> 1;
                u1 = run_up ? centre - half : centre + half;
                u2 = run_up ? centre + (mag - half) : centre - (mag - half);
                send_round(u1[31:0], u2[31:0]);
            end
        end
        wait_drained();
    endtask

    task automatic test_random_rounds();
        // Reset values, no idling on either side
        idle_on = 1'b0;
        configure(PROBE_FRACTION_RST, BASE_BOUND_RST, BOUND_INCREMENT_RST, MIN_RATE_RST,
                  START_RATE_RST);
        random_rounds(ROUNDS_PER_PHASE, -1, -1);

        // Largest fractions and bounds; receiver holds off while rounds keep coming
        idle_on = 1'b1;
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0, $urandom);
        random_rounds(ROUNDS_PER_PHASE, 20, -1);

        // Smallest fractions from a low rate
        configure(16'd1, 16'd0, 16'd1, $urandom_range(0, 4095), $urandom_range(0, 65535));
        random_rounds(ROUNDS_PER_PHASE, -1, -1);

        // Floor at the top: the rate is pinned at its maximum
        configure(16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)),
                  32'hFFFF_FFFF, 32'd0);
        random_rounds(ROUNDS_PER_PHASE, -1, -1);

        // Random settings, a zero increment now and then, and a sender pause
        repeat (2)
        begin
            configure(16'($urandom), 16'($urandom),
                      ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)),
                      $urandom >> $urandom_range(0, 31), $urandom >> $urandom_range(0, 8));
            random_rounds(ROUNDS_PER_PHASE, -1, ROUNDS_PER_PHASE / 2);
        end
    endtask

    task automatic check_field(input string name, input logic [STEP_W-1:0] want,
                               input logic [STEP_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare each accepted result with the oldest outstanding prediction
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_updates.size() == 0) begin
                $display("%0t: result with no round outstanding, new_rate %h",
                         $time, out_ch.new_rate);
                errors++;
            end else begin
                oldest_update = pending_updates.pop_front();
                check_field("new_rate", 33'(oldest_update.new_rate), 33'(out_ch.new_rate));
                check_field("probe_low_rate", 33'(oldest_update.low_rate),
                            33'(out_ch.probe_low_rate));
                check_field("probe_high_rate", 33'(oldest_update.high_rate),
                            33'(out_ch.probe_high_rate));
                check_field("rate_step", oldest_update.step, out_ch.rate_step);
                check_field("step_clamped", 33'(oldest_update.clamped), 33'(out_ch.step_clamped));
                check_field("streak_length", 33'(oldest_update.streak),
                            33'(out_ch.streak_length));
            end
        end
    end

    // Receiver: long hold-off on request, otherwise random stalls while idling is on
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (sink_hold > 0) begin
                out_ch.ready <= 1'b0;
                sink_hold--;
            end else if (sink_gap > 0) begin
                out_ch.ready <= 1'b0;
                sink_gap--;
            end else begin
                out_ch.ready <= 1'b1;
                if (idle_on)
                    sink_gap = pick_gap();
            end
        end
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.util_first = '0;
        in_ch.util_second = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_utility_extremes();
        test_special_cases();
        test_random_rounds();

        wait_drained();
        repeat (LATENCY_SLACK) @(posedge clk);
        if (errors == 0)
            $display("PASS probe_rate_controller_step_unit");
        else
            $display("FAIL probe_rate_controller_step_unit");
        $finish;
    end

    // Bound the run
    initial begin
        #10ms;
        $display("FAIL probe_rate_controller_step_unit");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/prcs_pkg.sv
sv/prcs_if.sv
sv/prcs_mul.sv
sv/prcs_div.sv
sv/prcs_cfg.sv
sv/probe_rate_controller_step_unit.sv
verif/probe_rate_controller_step_unit_tb.sv
